// ===== hw/rtl/exponential_backoff_retry_controller_defines.svh =====
// assertion macros for the backoff retry controller checker
// no dependencies; taken in by the checker file only
`ifndef EXPONENTIAL_BACKOFF_RETRY_CONTROLLER_DEFINES_SVH
`define EXPONENTIAL_BACKOFF_RETRY_CONTROLLER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define EBRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define EBRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ebrc_pkg.sv =====
// shared types and constants of the backoff retry controller
// no dependencies; used by the datapath, controller, top level and checker
`default_nettype none

package ebrc_pkg;

    // result action codes
    localparam logic [1:0] ACT_DONE   = 2'd0;
    localparam logic [1:0] ACT_GIVEUP = 2'd1;
    localparam logic [1:0] ACT_RETRY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_MAX   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    // field widths
    localparam int WIN_W = 32;
    localparam int RND_W = 64;
    localparam int ACT_W = 2;
    localparam int IDX_W = 2;

    // remainder unit retires two dividend bits a cycle
    localparam int DIV_STEPS  = RND_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic eval_retry;
        logic div_last;
        logic out_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ebrc_dp.sv =====
// datapath: config registers, window and failure count, remainder unit, output word
// depends on ebrc_pkg
`default_nettype none

module ebrc_dp (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [ebrc_pkg::IDX_W-1:0]   cfg_index,
    input  wire  [ebrc_pkg::WIN_W-1:0]   cfg_data,
    input  wire                          attempt_ok,
    input  wire  [ebrc_pkg::RND_W-1:0]   random_value,
    input  wire                          out_stall,
    input  ebrc_pkg::dp_cmd_t            cmd,
    output ebrc_pkg::dp_sts_t            sts,
    output logic                         out_valid,
    output logic [ebrc_pkg::ACT_W-1:0]   action,
    output logic [ebrc_pkg::WIN_W-1:0]   wait_ms
);
    import ebrc_pkg::*;

    logic [WIN_W-1:0]     base_reg, max_reg, limit_reg;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [WIN_W-1:0]     count_reg, count_next;
    logic                 ok_reg;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic [WIN_W-1:0]     divisor_reg;
    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic                 out_valid_reg;
    logic [ACT_W-1:0]     action_reg;
    logic [WIN_W-1:0]     wait_reg;

    logic [WIN_W-1:0]     base_eff, max_eff, cur_win, grown_win, cnt_inc;
    logic                 limit_hit;
    logic [WIN_W:0]       trial1, trial2, diff1, diff2;
    logic [WIN_W-1:0]     part1;

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= WIN_W'(1);
            max_reg   <= WIN_W'(1);
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:  base_reg  <= cfg_data;
                REG_MAX:   max_reg   <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // zero base or max behaves as one
    assign base_eff  = (base_reg == '0) ? WIN_W'(1) : base_reg;
    assign max_eff   = (max_reg == '0) ? WIN_W'(1) : max_reg;
    assign cur_win   = (window_reg == '0) ? base_eff : window_reg;
    assign grown_win = (cur_win <= (max_eff >> 1)) ? {cur_win[WIN_W-2:0], 1'b0} : max_eff;
    assign cnt_inc   = count_reg + WIN_W'(1);
    assign limit_hit = (limit_reg != '0) && (cnt_inc == limit_reg);

    // two restoring remainder steps per cycle
    assign trial1 = {rem_reg, rnd_reg[RND_W-1]};
    assign diff1  = trial1 - {1'b0, divisor_reg};
    assign part1  = diff1[WIN_W] ? trial1[WIN_W-1:0] : diff1[WIN_W-1:0];
    assign trial2 = {part1, rnd_reg[RND_W-2]};
    assign diff2  = trial2 - {1'b0, divisor_reg};

    // next-state of the working registers
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        rnd_next    = rnd_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        act_next    = act_reg;
        if (cmd.load_in)
        begin
            rnd_next = random_value;
        end
        if (cmd.eval)
        begin
            if (ok_reg)
            begin
                window_next = '0;
                count_next  = '0;
                act_next    = ACT_DONE;
            end
            else if (limit_hit)
            begin
                window_next = '0;
                count_next  = '0;
                act_next    = ACT_GIVEUP;
            end
            else
            begin
                if (limit_reg != '0)
                begin
                    count_next = cnt_inc;
                end
                window_next = grown_win;
                rem_next    = '0;
                step_next   = DIV_CNT_W'(DIV_STEPS - 1);
                act_next    = ACT_RETRY;
            end
        end
        if (cmd.div_step)
        begin
            rem_next  = diff2[WIN_W] ? trial2[WIN_W-1:0] : diff2[WIN_W-1:0];
            rnd_next  = {rnd_reg[RND_W-3:0], 2'b00};
            step_next = step_reg - DIV_CNT_W'(1);
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        rnd_reg  <= rnd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        act_reg  <= act_next;
        if (cmd.load_in)
        begin
            ok_reg <= attempt_ok;
        end
        if (cmd.eval)
        begin
            divisor_reg <= cur_win;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            action_reg <= act_reg;
            wait_reg   <= (act_reg == ACT_RETRY) ? rem_reg : '0;
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.eval_retry = !ok_reg && !limit_hit;
        sts.div_last   = (step_reg == '0);
        sts.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign wait_ms   = wait_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ebrc_ctrl.sv =====
// controller: sequences capture, evaluation, remainder steps and output load
// depends on ebrc_pkg
`default_nettype none

module ebrc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  ebrc_pkg::dp_sts_t   sts,
    output ebrc_pkg::dp_cmd_t   cmd
);
    import ebrc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.eval_retry ? S_DIV : S_POST;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/exponential_backoff_retry_controller.sv =====
// Sequence: done and give-up words go through the evaluation and output load states;
// retry words also run the remainder steps, two dividend bits per step, before the output load.
// One word in flight at a time: a new input word is taken only after the result
// is loaded into the output register; a stalled output word holds up that load.
// Reset (async, active low) sets base and max window to 1, limit to 0,
// clears window and failure count and empties the output register.
// top level: joins controller and datapath; depends on ebrc_pkg, ebrc_ctrl, ebrc_dp
`default_nettype none

module exponential_backoff_retry_controller (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [ebrc_pkg::IDX_W-1:0]   cfg_index,
    input  wire  [ebrc_pkg::WIN_W-1:0]   cfg_data,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          attempt_ok,
    input  wire  [ebrc_pkg::RND_W-1:0]   random_value,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [ebrc_pkg::ACT_W-1:0]   action,
    output logic [ebrc_pkg::WIN_W-1:0]   wait_ms
);
    import ebrc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    ebrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and storage
    ebrc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .attempt_ok   (attempt_ok),
        .random_value (random_value),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .action       (action),
        .wait_ms      (wait_ms)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ebrc_checker.sv =====
// port-level checks of the backoff retry controller, bound to the top level
// depends on ebrc_pkg and exponential_backoff_retry_controller_defines.svh
`default_nettype none
`include "exponential_backoff_retry_controller_defines.svh"

module ebrc_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire                          in_stall,
    input  wire                          out_valid,
    input  wire                          out_stall,
    input  wire  [ebrc_pkg::ACT_W-1:0]   action,
    input  wire  [ebrc_pkg::WIN_W-1:0]   wait_ms
);
    import ebrc_pkg::*;

    // a held result word keeps its payload
    `EBRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(action) && $stable(wait_ms),
                     "output word changed while stalled")

    // one word in flight: input closes after a take
    `EBRC_ASSERT_NXT(a_in_closes, clk, rst_n, in_valid && !in_stall, in_stall,
                     "input taken twice in a row")

    // only defined action codes leave the block
    `EBRC_ASSERT_IMP(a_act_code, clk, rst_n, out_valid,
                     action == ACT_DONE || action == ACT_GIVEUP || action == ACT_RETRY,
                     "undefined action code")

    // done and give-up carry no wait
    `EBRC_ASSERT_IMP(a_wait_zero, clk, rst_n, out_valid && action != ACT_RETRY,
                     wait_ms == '0, "nonzero wait without retry")

endmodule

bind exponential_backoff_retry_controller ebrc_checker u_ebrc_checker (.*);

`default_nettype wire

// ===== tb/backoff_result_checker.sv =====
`timescale 1ns / 100ps
// checker for the backoff retry controller: follows register writes, predicts each
// result word from the attempts taken and compares it with the words delivered
// depends on ebrc_pkg only
module backoff_result_checker
    import ebrc_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [IDX_W-1:0]    cfg_index,
    input  wire  [WIN_W-1:0]    cfg_data,
    input  wire                 in_valid,
    input  wire                 in_stall,
    input  wire                 attempt_ok,
    input  wire  [RND_W-1:0]    random_value,
    input  wire                 out_valid,
    input  wire                 out_stall,
    input  wire  [ACT_W-1:0]    action,
    input  wire  [WIN_W-1:0]    wait_ms,
    output int                  mismatches,
    output int                  outstanding,
    output int                  n_done,
    output int                  n_giveup,
    output int                  n_retry
);

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [WIN_W-1:0] delay;
    } backoff_word_t;

    backoff_word_t pending_results[$];

    // register copies and sequence state
    logic [WIN_W-1:0] base_reg;
    logic [WIN_W-1:0] max_reg;
    logic [WIN_W-1:0] limit_reg;
    logic [WIN_W-1:0] window_q;
    logic [WIN_W-1:0] fail_count;
    int               words_seen;

    // outcome of one attempt; advances window and failure count
    function automatic backoff_word_t next_backoff(input logic ok,
                                                   input logic [RND_W-1:0] rnd);
        backoff_word_t    res;
        logic [WIN_W-1:0] base_eff;
        logic [WIN_W-1:0] max_eff;
        logic [WIN_W-1:0] cur;
        logic [RND_W-1:0] rem;
        logic             give_up;
        base_eff = (base_reg == '0) ? WIN_W'(1) : base_reg;
        max_eff  = (max_reg == '0) ? WIN_W'(1) : max_reg;
        give_up  = 1'b0;
        res.act   = ACT_DONE;
        res.delay = '0;
        if (ok)
        begin
            window_q   = '0;
            fail_count = '0;
        end
        else
        begin
            // failures only counted under a finite limit
            if (limit_reg != '0)
            begin
                fail_count = fail_count + WIN_W'(1);
                give_up    = (fail_count == limit_reg);
            end
            if (give_up)
            begin
                window_q   = '0;
                fail_count = '0;
                res.act    = ACT_GIVEUP;
            end
            else
            begin
                cur       = (window_q != '0) ? window_q : base_eff;
                rem       = rnd % RND_W'(cur);
                res.act   = ACT_RETRY;
                res.delay = rem[WIN_W-1:0];
                // double, clamped to the largest window
                if (cur <= (max_eff >> 1))
                    window_q = cur << 1;
                else
                    window_q = max_eff;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        backoff_word_t exp_w;
        if (!rst_n)
        begin
            base_reg   = WIN_W'(1);
            max_reg    = WIN_W'(1);
            limit_reg  = '0;
            window_q   = '0;
            fail_count = '0;
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
            words_seen  = 0;
            n_done      = 0;
            n_giveup    = 0;
            n_retry     = 0;
        end
        else
        begin
            // register writes; spare index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE:  base_reg  = cfg_data;
                    REG_MAX:   max_reg   = cfg_data;
                    REG_LIMIT: limit_reg = cfg_data;
                    default: ;
                endcase
            end
            // attempt taken
            if (in_valid && !in_stall)
                pending_results.push_back(next_backoff(attempt_ok, random_value));
            // result word delivered
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d arrived with no attempt pending: action %0d wait %0d",
                                 words_seen, action, wait_ms);
                end
                else
                begin
                    exp_w = pending_results.pop_front();
                    case (exp_w.act)
                        ACT_DONE:   n_done++;
                        ACT_GIVEUP: n_giveup++;
                        default:    n_retry++;
                    endcase
                    if (action !== exp_w.act || wait_ms !== exp_w.delay)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d mismatch: expected action %0d wait %0d, got action %0d wait %0d",
                                     words_seen, exp_w.act, exp_w.delay, action, wait_ms);
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== tb/exponential_backoff_retry_controller_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the backoff retry controller: clock, reset, attempt stimulus,
// register settings, output stalls and the verdict
// depends on ebrc_pkg, exponential_backoff_retry_controller and backoff_result_checker
module exponential_backoff_retry_controller_tb;
    import ebrc_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEGMENTS    = 8;
    localparam int SEG_WORDS   = 156;
    localparam int OK_PCT      = 20;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [WIN_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               attempt_ok;
    logic [RND_W-1:0]   random_value;
    logic               out_valid;
    logic               out_stall;
    logic [ACT_W-1:0]   action;
    logic [WIN_W-1:0]   wait_ms;

    int src_idle_pct;
    int snk_stall_pct;
    int hold_ticket;
    int hold_taken;
    int hold_left;
    int cycles;
    int settings_used;
    int mismatches;
    int outstanding;
    int n_done;
    int n_giveup;
    int n_retry;

    exponential_backoff_retry_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .attempt_ok   (attempt_ok),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .wait_ms      (wait_ms)
    );

    backoff_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .attempt_ok   (attempt_ok),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .wait_ms      (wait_ms),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .n_done       (n_done),
        .n_giveup     (n_giveup),
        .n_retry      (n_retry)
    );

    always #(CLK_HALF) clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_taken != hold_ticket)
        begin
            hold_taken <= hold_ticket;
            hold_left  <= HOLD_CYCLES - 1;
            out_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // offer one attempt word, with random gaps first, and wait until taken
    task automatic send_attempt(input logic ok, input logic [RND_W-1:0] rnd);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        attempt_ok   <= ok;
        random_value <= rnd;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering and wait for every result word to come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // new window and limit settings, written while idle
    task automatic apply_setting(input logic [WIN_W-1:0] b, input logic [WIN_W-1:0] m,
                                 input logic [WIN_W-1:0] l);
        wait_idle();
        write_reg(REG_BASE, b);
        write_reg(REG_MAX, m);
        write_reg(REG_LIMIT, l);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // nonzero window of random magnitude
    function automatic logic [WIN_W-1:0] rand_window();
        logic [WIN_W-1:0] v;
        v = $urandom >> $urandom_range(31);
        return (v == '0) ? WIN_W'(1) : v;
    endfunction

    // jitter word: mostly full width, sometimes short
    function automatic logic [RND_W-1:0] rand_jitter();
        logic [RND_W-1:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            r = r >> $urandom_range(63);
        return r;
    endfunction

    initial
    begin
        int               seg;
        int               n;
        logic [WIN_W-1:0] b;
        logic [WIN_W-1:0] m;
        logic [WIN_W-1:0] l;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        attempt_ok    = 1'b0;
        random_value  = '0;
        out_stall     = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_ticket   = 0;
        hold_taken    = 0;
        hold_left     = 0;
        cycles        = 0;
        settings_used = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: window of one gives zero wait
        send_attempt(1'b0, '0);
        send_attempt(1'b0, '1);
        send_attempt(1'b1, RND_W'(64'h1234));

        // window grows from base to max, then stays
        apply_setting(32'd5, 32'd40, 32'd0);
        send_attempt(1'b0, '1);
        send_attempt(1'b0, 64'h8000_0000_0000_0000);
        send_attempt(1'b0, RND_W'(39));
        send_attempt(1'b0, RND_W'(12345));
        send_attempt(1'b0, '1);
        send_attempt(1'b1, '0);

        // spare register index, then give-up on the third failure
        wait_idle();
        write_reg(REG_SPARE, 32'd7);
        apply_setting(32'd5, 32'd40, 32'd3);
        send_attempt(1'b0, RND_W'(7));
        send_attempt(1'b0, RND_W'(7));
        send_attempt(1'b0, RND_W'(7));
        send_attempt(1'b0, RND_W'(7));
        send_attempt(1'b0, '1);

        // limit lowered below the count mid-sequence
        apply_setting(32'd5, 32'd40, 32'd1);
        send_attempt(1'b0, RND_W'(9));
        send_attempt(1'b1, '0);

        // base above max
        apply_setting(32'hFFFF_FFFF, 32'd2, 32'd0);
        send_attempt(1'b0, '1);
        send_attempt(1'b0, '1);
        send_attempt(1'b0, RND_W'(3));
        send_attempt(1'b1, '0);

        // widest windows and limit
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_attempt(1'b0, '1);
        send_attempt(1'b0, '0);
        send_attempt(1'b0, 64'hFFFF_FFFE_0000_0001);
        send_attempt(1'b1, '1);

        // random segments, each with its own setting and one of four idling modes
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       begin b = 32'd1;          m = 32'd1;          l = 32'd0;          end
                1:       begin b = 32'd3;          m = 32'd100;        l = 32'd6;          end
                2:       begin b = 32'hFFFF_FFFF;  m = 32'hFFFF_FFFF;  l = 32'd1;          end
                3:       begin b = 32'd1000;       m = 32'd10;         l = 32'd3;          end
                4:       begin b = 32'd1;          m = 32'hFFFF_FFFF;  l = 32'd0;          end
                5:       begin b = rand_window();  m = rand_window();  l = $urandom_range(12, 1); end
                6:       begin b = 32'h8000_0000;  m = 32'hFFFF_FFFF;  l = 32'hFFFF_FFFF;  end
                default: begin b = rand_window();  m = rand_window();  l = 32'd0;          end
            endcase
            apply_setting(b, m, l);
            case (seg % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 56; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 56; end
                default: begin src_idle_pct = 30; snk_stall_pct = 30; end
            endcase
            // long output hold-off while attempts keep coming
            if (seg == 1)
                hold_ticket++;
            for (n = 0; n < SEG_WORDS; n++)
                send_attempt($urandom_range(99) < OK_PCT, rand_jitter());
        end

        wait_idle();
        repeat (40) @(posedge clk);

        $display("%0d result words checked: %0d done, %0d give-up, %0d retry",
                 n_done + n_giveup + n_retry, n_done, n_giveup, n_retry);
        $display("%0d register settings, sender gaps, output stalls and one long hold-off",
                 settings_used);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
